### src/sobel_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
`default_nettype none
package sobel_pkg;

    localparam int PIX_W      = 8;
    localparam int NCH        = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FW_W       = 12;
    localparam int FH_W       = 16;
    localparam int GRAD_W     = 12;
    localparam int SUM_W      = 25;
    localparam int ROOT_W     = 8;
    localparam int N_W        = 16;

    localparam logic [0:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd2048;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd1;

    // 255.5 squared rounds up to this
    localparam logic [SUM_W-1:0] SAT_LIMIT = 25'd65281;
    localparam logic [PIX_W-1:0] MAG_MAX   = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GRAD,
        ST_SQUARE,
        ST_ROOT,
        ST_ROUND
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
        logic grad;
        logic square;
        logic root_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic due;
        logic root_last;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

### src/sobel_ctrl.sv
// Sequencer for one item: load window, then, once a result is due, gradients, squares, root, result.
`default_nettype none
module sobel_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  sobel_pkg::t_status  i_status,
    output logic                o_in_stall,
    output sobel_pkg::t_cmd     o_cmd,
    output sobel_pkg::t_state   o_state
);

    sobel_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sobel_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sobel_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sobel_pkg::ST_LOAD;
            end
            sobel_pkg::ST_LOAD: begin
                n_state = i_status.due ? sobel_pkg::ST_GRAD : sobel_pkg::ST_IDLE;
            end
            sobel_pkg::ST_GRAD:   n_state = sobel_pkg::ST_SQUARE;
            sobel_pkg::ST_SQUARE: n_state = sobel_pkg::ST_ROOT;
            sobel_pkg::ST_ROOT: begin
                if (i_status.root_last) n_state = sobel_pkg::ST_ROUND;
            end
            sobel_pkg::ST_ROUND: begin
                // hold until the output register can take the result
                if (i_status.out_free) n_state = sobel_pkg::ST_IDLE;
            end
            default: n_state = sobel_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            sobel_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            sobel_pkg::ST_LOAD:   o_cmd.load      = 1'b1;
            sobel_pkg::ST_GRAD:   o_cmd.grad      = 1'b1;
            sobel_pkg::ST_SQUARE: o_cmd.square    = 1'b1;
            sobel_pkg::ST_ROOT:   o_cmd.root_step = 1'b1;
            sobel_pkg::ST_ROUND:  o_cmd.finish    = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

    assign o_state = r_state;

endmodule
`default_nettype wire

### src/sobel_dp.sv
// Datapath: line stores, window, position counters, gradients and square root.
`default_nettype none
module sobel_dp #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  sobel_pkg::t_cmd                  i_cmd,
    output sobel_pkg::t_status               o_status,
    input  wire                              i_cfg_we,
    input  wire [0:0]                        i_cfg_idx,
    input  wire [sobel_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire [sobel_pkg::PIX_W-1:0]       i_red_in,
    input  wire [sobel_pkg::PIX_W-1:0]       i_green_in,
    input  wire [sobel_pkg::PIX_W-1:0]       i_blue_in,
    input  wire                              i_flush,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [sobel_pkg::PIX_W-1:0]      o_red_edge,
    output logic [sobel_pkg::PIX_W-1:0]      o_green_edge,
    output logic [sobel_pkg::PIX_W-1:0]      o_blue_edge,
    output logic                             o_frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int PW = sobel_pkg::PIX_W;
    localparam int HW = sobel_pkg::FH_W;
    localparam int GW = sobel_pkg::GRAD_W;
    localparam int RW = sobel_pkg::ROOT_W;
    localparam int NW = sobel_pkg::N_W;

    logic [3*PW-1:0] upper_mem [MAX_WIDTH];
    logic [3*PW-1:0] lower_mem [MAX_WIDTH];

    logic [sobel_pkg::FW_W-1:0] r_frame_width;
    logic [HW-1:0]              r_frame_height;
    logic [CW-1:0]              r_in_col, r_out_col;
    logic [HW-1:0]              r_in_row, r_out_row;
    logic [3*PW-1:0]            r_pix, r_top, r_mid;
    logic [PW-1:0]              r_win [3][3][3];
    logic signed [GW-1:0]       r_gx [3];
    logic signed [GW-1:0]       r_gy [3];
    logic [NW-1:0]              r_n [3];
    logic                       r_sat [3];
    logic [RW-1:0]              r_root [3];
    logic [RW-1:0]              r_bit;
    logic                       r_out_valid;
    logic [PW-1:0]              r_edge [3];
    logic                       r_last;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] w_h;
    logic          w_in_col_end, w_out_col_end, w_out_row_end, w_last;
    logic          w_due;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        w_h = (r_frame_height == '0) ? HW'(1) : r_frame_height;
    end

    assign w_in_col_end  = ({1'b0, r_in_col} + WW'(1)) >= w_eff;
    assign w_out_col_end = ({1'b0, r_out_col} + WW'(1)) >= w_eff;
    assign w_out_row_end = ({1'b0, r_out_row} + 17'd1) >= {1'b0, w_h};
    assign w_last        = w_out_col_end && w_out_row_end;
    assign w_due         = (r_in_row >= HW'(2)) || (r_in_row == HW'(1) && r_in_col != '0);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= sobel_pkg::FRAME_WIDTH_RST;
            r_frame_height <= sobel_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sobel_pkg::CFG_FRAME_WIDTH:
                    r_frame_width <= i_cfg_wdata[sobel_pkg::FW_W-1:0];
                sobel_pkg::CFG_FRAME_HEIGHT:
                    r_frame_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // latch the pixel; beyond the frame or on flush it counts as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (i_flush || r_in_row >= w_h) begin
                r_pix <= '0;
            end else begin
                r_pix <= {i_blue_in, i_green_in, i_red_in};
            end
        end
    end

    // line stores: read on transfer, written back in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_top <= upper_mem[r_in_col];
            r_mid <= lower_mem[r_in_col];
        end
        if (i_cmd.load) begin
            upper_mem[r_in_col] <= r_mid;
            lower_mem[r_in_col] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++)
                    for (int c = 0; c < 3; c++)
                        r_win[r][k][c] <= '0;
        end else if (i_cmd.load) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0][c] <= r_win[r][1][c];
                    r_win[r][1][c] <= r_win[r][2][c];
                end
                r_win[0][2][c] <= r_top[c*PW +: PW];
                r_win[1][2][c] <= r_mid[c*PW +: PW];
                r_win[2][2][c] <= r_pix[c*PW +: PW];
            end
        end
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cmd.load) begin
            if (w_in_col_end) begin
                r_in_col <= '0;
                if (r_in_row != '1) r_in_row <= r_in_row + HW'(1);
            end else begin
                r_in_col <= r_in_col + CW'(1);
            end
        end else if (i_cmd.finish) begin
            if (w_last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (w_out_col_end) begin
                r_out_col <= '0;
                r_out_row <= r_out_row + HW'(1);
            end else begin
                r_out_col <= r_out_col + CW'(1);
            end
        end
    end

    // gradients over the masked window
    always_ff @(posedge i_clk) begin
        logic signed [GW-1:0] p [3][3];
        if (i_cmd.grad) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    for (int k = 0; k < 3; k++) begin
                        p[r][k] = GW'(r_win[r][k][c]);
                        if ((r == 0 && r_out_row == '0) || (r == 2 && w_out_row_end) ||
                            (k == 0 && r_out_col == '0) || (k == 2 && w_out_col_end))
                            p[r][k] = '0;
                    end
                end
                r_gx[c] <= (p[0][2] - p[0][0]) + ((p[1][2] - p[1][0]) <<< 1)
                         + (p[2][2] - p[2][0]);
                r_gy[c] <= (p[2][0] + (p[2][1] <<< 1) + p[2][2])
                         - (p[0][0] + (p[0][1] <<< 1) + p[0][2]);
            end
        end
    end

    // squares, then square root one bit a cycle
    always_ff @(posedge i_clk) begin
        logic [sobel_pkg::SUM_W-1:0] sum;
        logic signed [2*GW-1:0]      sq_x, sq_y;
        logic [RW-1:0]               t;
        if (i_cmd.square) begin
            for (int c = 0; c < 3; c++) begin
                sq_x = (2*GW)'(r_gx[c]) * (2*GW)'(r_gx[c]);
                sq_y = (2*GW)'(r_gy[c]) * (2*GW)'(r_gy[c]);
                sum  = sobel_pkg::SUM_W'($unsigned(sq_x))
                     + sobel_pkg::SUM_W'($unsigned(sq_y));
                r_sat[c]  <= sum >= sobel_pkg::SAT_LIMIT;
                r_n[c]    <= sum[NW-1:0];
                r_root[c] <= '0;
            end
            r_bit <= {1'b1, {(RW-1){1'b0}}};
        end else if (i_cmd.root_step) begin
            for (int c = 0; c < 3; c++) begin
                t = r_root[c] | r_bit;
                if ((NW'(t) * NW'(t)) <= r_n[c]) r_root[c] <= t;
            end
            r_bit <= r_bit >> 1;
        end
    end

    // round to nearest, saturate at MAG_MAX, and hold in the output register
    always_ff @(posedge i_clk) begin
        logic [NW-1:0] rem;
        if (i_cmd.finish) begin
            for (int c = 0; c < 3; c++) begin
                rem = r_n[c] - NW'(r_root[c]) * NW'(r_root[c]);
                if (r_sat[c]) begin
                    r_edge[c] <= sobel_pkg::MAG_MAX;
                end else if (rem > NW'(r_root[c])) begin
                    r_edge[c] <= r_root[c] + RW'(1);
                end else begin
                    r_edge[c] <= r_root[c];
                end
            end
            r_last <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.due       = w_due;
    assign o_status.root_last = r_bit[0];
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_red_edge   = r_edge[0];
    assign o_green_edge = r_edge[1];
    assign o_blue_edge  = r_edge[2];
    assign o_frame_last = r_last;

endmodule
`default_nettype wire

### src/sobel_edge_magnitude_rgb.sv
// A result passes the load, gradient, square, root and round steps after the transfer
// that completes it. A new item is taken only once the previous one is through; items
// with a result take longest, through the eight-step square-root iteration.
// Results lag the pixel stream by one row plus one pixel.
// Reset is synchronous, active low; line stores are not cleared.
// Settings after reset: width 2048, height 1.
`default_nettype none
module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [0:0]                        i_cfg_idx,
    input  wire [sobel_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire [sobel_pkg::PIX_W-1:0]       i_red_in,
    input  wire [sobel_pkg::PIX_W-1:0]       i_green_in,
    input  wire [sobel_pkg::PIX_W-1:0]       i_blue_in,
    input  wire                              i_flush,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [sobel_pkg::PIX_W-1:0]      o_red_edge,
    output logic [sobel_pkg::PIX_W-1:0]      o_green_edge,
    output logic [sobel_pkg::PIX_W-1:0]      o_blue_edge,
    output logic                             o_frame_last
);

    sobel_pkg::t_cmd    w_cmd;
    sobel_pkg::t_status w_status;
    sobel_pkg::t_state  w_state;

    sobel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    sobel_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_flush      (i_flush),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_red_edge   (o_red_edge),
        .o_green_edge (o_green_edge),
        .o_blue_edge  (o_blue_edge),
        .o_frame_last (o_frame_last)
    );

    // a new result appears only out of the rounding step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_state == sobel_pkg::ST_ROUND))
        else $error("result appeared outside the rounding step");

    // transfers in are taken only while the sequencer is idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> w_state == sobel_pkg::ST_IDLE)
        else $error("input taken while busy");

    // the rounding step never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.finish && o_out_valid) |-> !i_out_stall)
        else $error("result overwritten");

endmodule
`default_nettype wire
